### design/dcow_pkg.sv
// ----------------------------------------------------------------------------
// dcow_pkg
// Shared types, codes and field layout of the deduplicated copy-on-write
// block store.
// ----------------------------------------------------------------------------
package dcow_pkg;

   localparam int BLOCK_SHIFT_DEF = 7;
   localparam int PAGE_COUNT_DEF  = 16384;
   localparam int MAX_BLOCKS_DEF  = 1024;

   localparam int ACT_W    = 3;
   localparam int CP_W     = 21;
   localparam int ADDR_W   = 23;
   localparam int BYTE_W   = 8;
   localparam int BLKNUM_W = 11;
   localparam int REF_W    = 15;
   localparam int ST_W     = 2;

   localparam int REQ_ACT_LSB  = 0;
   localparam int REQ_CP_LSB   = REQ_ACT_LSB + ACT_W;
   localparam int REQ_ADDR_LSB = REQ_CP_LSB + CP_W;
   localparam int REQ_NB_LSB   = REQ_ADDR_LSB + ADDR_W;
   localparam int REQ_BITS     = REQ_NB_LSB + BYTE_W;
   localparam int REQ_TDATA_W  = ((REQ_BITS + 7) / 8) * 8;

   localparam int RSP_BITS    = BLKNUM_W + BYTE_W + 3 + REF_W + ST_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [REF_W-1:0] REF_MAX = '1;

   localparam logic [ACT_W-1:0] ACT_LOAD   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_FILL   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_MODIFY = 3'd2;

   typedef enum logic [ST_W-1:0] {
      ST_OK       = 2'd0,
      ST_UNMAPPED = 2'd1,
      ST_FULL     = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef struct packed {
      logic [REF_W-1:0]  refs;
      logic              forked;
      logic [ADDR_W-1:0] origin;
   } meta_type;

   typedef enum logic [2:0] {
      PW_NONE, PW_CLEAR, PW_TGT_CLEAN, PW_TGT_DIRTY, PW_B_DIRTY
   } pg_wr_type;

   typedef enum logic [2:0] {
      MW_NONE, MW_INC, MW_DEC, MW_NEW_LOAD, MW_NEW_FORK
   } meta_wr_type;

   typedef enum logic {MR_B, MR_CAND} meta_rd_type;

   typedef enum logic [1:0] {TG_HOLD, TG_CAND, TG_ZERO, TG_NEW} tgt_op_type;

   typedef enum logic [1:0] {CD_HOLD, CD_FIRST, CD_NEXT} cand_op_type;

   typedef struct packed {
      logic        load_item;
      logic        clr_step;
      pg_wr_type   pg_wr;
      logic        cap_page;
      logic        cap_bmeta;
      logic        cap_tmeta;
      logic        cap_byte;
      meta_rd_type meta_rd;
      meta_wr_type meta_wr;
      tgt_op_type  tgt_op;
      cand_op_type cand_op;
      logic        byte_wr;
      logic        byte_set_nb;
      logic        seq_start;
      logic        cmp_step;
      logic        copy_step;
      logic        st_set;
      status_type  st_code;
      logic        changed_set;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic clr_last;
      logic oor;
      logic addr_zero;
      logic b_zero;
      logic byte_same;
      logic b_sole_orig;
      logic b_ref_one;
      logic leave_ok;
      logic full;
      logic cand_past;
      logic load_hit;
      logic cand_live;
      logic cmp_miss;
      logic cmp_hit;
      logic copy_done;
      logic rsp_free;
   } sts_type;

endpackage

### design/dcow_ram.sv
// ----------------------------------------------------------------------------
// dcow_ram
// Generic RAM: port A reads or writes, port B reads, both reads registered.
// ----------------------------------------------------------------------------
module dcow_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] a_addr,
   input  logic                     a_we,
   input  logic [WIDTH-1:0]         a_wdata,
   output logic [WIDTH-1:0]         a_rdata,
   input  logic [$clog2(DEPTH)-1:0] b_addr,
   output logic [WIDTH-1:0]         b_rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (a_we) begin
         mem[a_addr] <= a_wdata;
      end
      a_rdata <= mem[a_addr];
      b_rdata <= mem[b_addr];
   end

endmodule

### design/dcow_datapath.sv
// ----------------------------------------------------------------------------
// dcow_datapath
// Page table, block metadata and byte store with the registers that carry
// one transaction, the block compare/copy sequencer and the result register.
// ----------------------------------------------------------------------------
module dcow_datapath import dcow_pkg::*; #(
   parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEF,
   parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
   parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int PAGE_W = $clog2(PAGE_COUNT);
   localparam int PGF_W  = CP_W - BLOCK_SHIFT;
   localparam int PGX_W  = (PAGE_W > PGF_W) ? PAGE_W : PGF_W;
   localparam int BLK_W  = $clog2(MAX_BLOCKS + 1);
   localparam int CAND_W = $clog2(MAX_BLOCKS + 2);
   localparam int BIX_W  = $clog2(MAX_BLOCKS);
   localparam int BA_W   = BIX_W + BLOCK_SHIFT;
   localparam int IDX_W  = BLOCK_SHIFT + 1;
   localparam int PE_W   = BLK_W + 1;
   localparam int META_W = $bits(meta_type);
   localparam int PAD_W  = RSP_TDATA_W - RSP_BITS;

   logic [ACT_W-1:0]       act_ff;
   logic [PGF_W-1:0]       page_ff;
   logic [BLOCK_SHIFT-1:0] off_ff;
   logic [ADDR_W-1:0]      addr_ff;
   logic [BYTE_W-1:0]      nb_ff;
   logic [BLK_W-1:0]       b_ff, tgt_ff, biu_ff;
   logic                   dirty_ff, changed_ff, chk_v_ff, rsp_valid_ff;
   meta_type               bmeta_ff, tmeta_ff;
   logic [BYTE_W-1:0]      byte_ff;
   logic [CAND_W-1:0]      cand_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [BLOCK_SHIFT-1:0] chk_idx_ff;
   logic [PAGE_W-1:0]      clr_cnt_ff;
   status_type             status_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [PGX_W-1:0]  page_x;
   logic [PAGE_W-1:0] pg_addr;
   logic              pg_we;
   logic [PE_W-1:0]   pg_wdata, pg_rdata;
   logic [BIX_W-1:0]  meta_addr, b_ix, tgt_ix;
   logic              meta_we;
   meta_type          meta_wdata, meta_rdata;
   logic [REF_W-1:0]  inc_refs;
   logic [BA_W-1:0]   byte_a_addr, byte_b_addr;
   logic              byte_a_we;
   logic [BYTE_W-1:0] byte_a_wdata, byte_rda, byte_rdb, want;
   logic              mapped, oor_out, last_chk;
   logic [RSP_BITS-1:0] rsp_bits;

   assign page_x = PGX_W'(page_ff);
   assign b_ix   = BIX_W'(b_ff - BLK_W'(1));
   assign tgt_ix = BIX_W'(tgt_ff - BLK_W'(1));
   assign inc_refs = (tmeta_ff.refs == REF_MAX) ? tmeta_ff.refs : tmeta_ff.refs + REF_W'(1);
   assign last_chk = (chk_idx_ff == '1);

   // Page table: block number above, dirty mark in bit 0
   always_comb begin
      pg_addr  = (cmd.pg_wr == PW_CLEAR) ? clr_cnt_ff : page_x[PAGE_W-1:0];
      pg_we    = (cmd.pg_wr != PW_NONE);
      unique case (cmd.pg_wr)
         PW_TGT_CLEAN: pg_wdata = {tgt_ff, 1'b0};
         PW_TGT_DIRTY: pg_wdata = {tgt_ff, 1'b1};
         PW_B_DIRTY:   pg_wdata = {b_ff, 1'b1};
         default:      pg_wdata = '0;
      endcase
   end

   dcow_ram #(.WIDTH(PE_W), .DEPTH(PAGE_COUNT)) u_page_ram (
      .clock   (clock),
      .a_addr  (pg_addr),
      .a_we    (pg_we),
      .a_wdata (pg_wdata),
      .a_rdata (pg_rdata),
      .b_addr  (pg_addr),
      .b_rdata ()
   );

   always_comb begin
      meta_we = (cmd.meta_wr != MW_NONE);
      unique case (cmd.meta_wr)
         MW_INC: begin
            meta_addr  = tgt_ix;
            meta_wdata = '{refs: inc_refs, forked: tmeta_ff.forked, origin: tmeta_ff.origin};
         end
         MW_DEC: begin
            meta_addr  = b_ix;
            meta_wdata = '{refs: bmeta_ff.refs - REF_W'(1), forked: bmeta_ff.forked,
                           origin: bmeta_ff.origin};
         end
         MW_NEW_LOAD: begin
            meta_addr  = BIX_W'(biu_ff);
            meta_wdata = '{refs: REF_W'(1), forked: 1'b0, origin: addr_ff};
         end
         MW_NEW_FORK: begin
            meta_addr  = BIX_W'(biu_ff);
            meta_wdata = '{refs: REF_W'(1), forked: 1'b1, origin: '0};
         end
         default: begin
            meta_addr  = (cmd.meta_rd == MR_CAND) ? BIX_W'(cand_ff - CAND_W'(1)) : b_ix;
            meta_wdata = '0;
         end
      endcase
   end

   dcow_ram #(.WIDTH(META_W), .DEPTH(MAX_BLOCKS)) u_meta_ram (
      .clock   (clock),
      .a_addr  (meta_addr),
      .a_we    (meta_we),
      .a_wdata (meta_wdata),
      .a_rdata (meta_rdata),
      .b_addr  (meta_addr),
      .b_rdata ()
   );

   // Byte store: port A serves the addressed byte, the compare source and
   // the copy writes; port B walks the other block
   always_comb begin
      want = (chk_idx_ff == off_ff) ? nb_ff : byte_rda;
      if (cmd.copy_step) begin
         byte_a_addr  = {tgt_ix, chk_idx_ff};
         byte_a_we    = chk_v_ff;
         byte_a_wdata = (chk_idx_ff == off_ff) ? nb_ff : byte_rdb;
         byte_b_addr  = {b_ix, idx_ff[BLOCK_SHIFT-1:0]};
      end else if (cmd.cmp_step) begin
         byte_a_addr  = {b_ix, idx_ff[BLOCK_SHIFT-1:0]};
         byte_a_we    = 1'b0;
         byte_a_wdata = nb_ff;
         byte_b_addr  = {tgt_ix, idx_ff[BLOCK_SHIFT-1:0]};
      end else begin
         byte_a_addr  = {b_ix, off_ff};
         byte_a_we    = cmd.byte_wr;
         byte_a_wdata = nb_ff;
         byte_b_addr  = {tgt_ix, idx_ff[BLOCK_SHIFT-1:0]};
      end
   end

   dcow_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_BLOCKS << BLOCK_SHIFT)) u_byte_ram (
      .clock   (clock),
      .a_addr  (byte_a_addr),
      .a_we    (byte_a_we),
      .a_wdata (byte_a_wdata),
      .a_rdata (byte_rda),
      .b_addr  (byte_b_addr),
      .b_rdata (byte_rdb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         biu_ff       <= '0;
         clr_cnt_ff   <= '0;
         chk_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_item) begin
            act_ff     <= req_tdata[REQ_ACT_LSB +: ACT_W];
            page_ff    <= req_tdata[REQ_CP_LSB + BLOCK_SHIFT +: PGF_W];
            off_ff     <= req_tdata[REQ_CP_LSB +: BLOCK_SHIFT];
            addr_ff    <= req_tdata[REQ_ADDR_LSB +: ADDR_W];
            nb_ff      <= req_tdata[REQ_NB_LSB +: BYTE_W];
            status_ff  <= ST_OK;
            changed_ff <= 1'b0;
         end
         if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + PAGE_W'(1);
         end
         if (cmd.cap_page) begin
            b_ff     <= pg_rdata[PE_W-1:1];
            dirty_ff <= pg_rdata[0];
         end
         unique case (cmd.pg_wr)
            PW_TGT_CLEAN, PW_TGT_DIRTY: begin
               b_ff     <= tgt_ff;
               bmeta_ff <= tmeta_ff;
               dirty_ff <= (cmd.pg_wr == PW_TGT_DIRTY);
            end
            PW_B_DIRTY: dirty_ff <= 1'b1;
            default: ;
         endcase
         if (cmd.cap_bmeta) begin
            bmeta_ff <= meta_rdata;
         end
         if (cmd.cap_tmeta) begin
            tmeta_ff <= meta_rdata;
         end
         unique case (cmd.meta_wr)
            MW_INC: tmeta_ff.refs <= inc_refs;
            MW_NEW_LOAD, MW_NEW_FORK: begin
               tmeta_ff <= meta_wdata;
               biu_ff   <= biu_ff + BLK_W'(1);
            end
            default: ;
         endcase
         unique case (cmd.tgt_op)
            TG_CAND: tgt_ff <= BLK_W'(cand_ff);
            TG_ZERO: begin
               tgt_ff   <= '0;
               tmeta_ff <= '0;
            end
            TG_NEW:  tgt_ff <= biu_ff + BLK_W'(1);
            default: ;
         endcase
         unique case (cmd.cand_op)
            CD_FIRST: cand_ff <= CAND_W'(1);
            CD_NEXT:  cand_ff <= cand_ff + CAND_W'(1);
            default: ;
         endcase
         if (cmd.cap_byte) begin
            byte_ff <= byte_rda;
         end
         if (cmd.byte_set_nb) begin
            byte_ff <= nb_ff;
         end
         if (cmd.seq_start) begin
            idx_ff   <= '0;
            chk_v_ff <= 1'b0;
         end else if (cmd.cmp_step || cmd.copy_step) begin
            if (!idx_ff[BLOCK_SHIFT]) begin
               idx_ff     <= idx_ff + IDX_W'(1);
               chk_v_ff   <= 1'b1;
               chk_idx_ff <= idx_ff[BLOCK_SHIFT-1:0];
            end else begin
               chk_v_ff <= 1'b0;
            end
         end
         if (cmd.st_set) begin
            status_ff <= cmd.st_code;
         end
         if (cmd.changed_set) begin
            changed_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= {{PAD_W{1'b0}}, rsp_bits};
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result fields: block fields read as zero for an unmapped page
   always_comb begin
      oor_out  = (status_ff == ST_RANGE);
      mapped   = (b_ff != '0) && !oor_out;
      rsp_bits = {status_ff,
                  mapped ? bmeta_ff.refs : REF_W'(0),
                  mapped & bmeta_ff.forked,
                  !oor_out & dirty_ff,
                  changed_ff,
                  mapped ? byte_ff : BYTE_W'(0),
                  mapped ? BLKNUM_W'(b_ff) : BLKNUM_W'(0)};
   end

   always_comb begin
      sts.act         = act_ff;
      sts.clr_last    = (clr_cnt_ff == PAGE_W'(PAGE_COUNT - 1));
      sts.oor         = ({1'b0, page_x} >= (PGX_W + 1)'(PAGE_COUNT));
      sts.addr_zero   = (addr_ff == '0);
      sts.b_zero      = (b_ff == '0);
      sts.byte_same   = (byte_ff == nb_ff);
      sts.b_sole_orig = (bmeta_ff.refs == REF_W'(1)) && !bmeta_ff.forked;
      sts.b_ref_one   = (bmeta_ff.refs == REF_W'(1));
      sts.leave_ok    = (b_ff != '0) && bmeta_ff.forked && (bmeta_ff.refs != '0);
      sts.full        = (biu_ff == BLK_W'(MAX_BLOCKS));
      sts.cand_past   = (cand_ff > CAND_W'(biu_ff));
      sts.load_hit    = !meta_rdata.forked && (meta_rdata.refs != '0)
                        && (meta_rdata.origin == addr_ff);
      sts.cand_live   = (meta_rdata.refs != '0);
      sts.cmp_miss    = chk_v_ff && (want != byte_rdb);
      sts.cmp_hit     = chk_v_ff && (want == byte_rdb) && last_chk;
      sts.copy_done   = chk_v_ff && last_chk;
      sts.rsp_free    = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### design/dcow_ctrl.sv
// ----------------------------------------------------------------------------
// dcow_ctrl
// Sequencer: page table clear after reset, then one transaction at a time
// through lookup, search, compare, copy and write-back.
// ----------------------------------------------------------------------------
module dcow_ctrl import dcow_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_PG_CAP, S_BLK_RD, S_BLK_CAP, S_DISPATCH,
      S_L_RD, S_L_CHK, S_L_INC, S_L_LEAVE, S_L_PG, S_L_BYTE, S_L_CAPB,
      S_M_NEXT, S_M_MCHK, S_M_CMP, S_M_COPY, S_M_INC, S_M_LEAVE, S_M_PG,
      S_PG_DIRTY, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rdy_ff, rdy_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      rdy_in   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.pg_wr    = PW_CLEAR;
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
               rdy_in   = 1'b1;
            end
         end
         S_IDLE: begin
            rdy_in = 1'b1;
            if (req_tvalid && rdy_ff) begin
               cmd.load_item = 1'b1;
               state_in      = S_CHECK;
               rdy_in        = 1'b0;
            end
         end
         S_CHECK: begin
            if (sts.oor) begin
               cmd.st_set  = 1'b1;
               cmd.st_code = ST_RANGE;
               state_in    = S_OUT;
            end else begin
               state_in = S_PG_CAP;
            end
         end
         S_PG_CAP: begin
            cmd.cap_page = 1'b1;
            state_in     = S_BLK_RD;
         end
         S_BLK_RD: state_in = S_BLK_CAP;
         S_BLK_CAP: begin
            cmd.cap_bmeta = 1'b1;
            cmd.cap_byte  = 1'b1;
            state_in      = S_DISPATCH;
         end
         S_DISPATCH: begin
            unique case (sts.act)
               ACT_LOAD: begin
                  if (sts.addr_zero) begin
                     cmd.tgt_op = TG_ZERO;
                     state_in   = S_L_LEAVE;
                  end else begin
                     cmd.cand_op = CD_FIRST;
                     state_in    = S_L_RD;
                  end
               end
               ACT_FILL: begin
                  if (sts.b_zero) begin
                     cmd.st_set  = 1'b1;
                     cmd.st_code = ST_UNMAPPED;
                  end else begin
                     cmd.byte_wr     = 1'b1;
                     cmd.byte_set_nb = 1'b1;
                  end
                  state_in = S_OUT;
               end
               ACT_MODIFY: begin
                  if (sts.b_zero) begin
                     cmd.st_set  = 1'b1;
                     cmd.st_code = ST_UNMAPPED;
                     state_in    = S_OUT;
                  end else if (sts.byte_same) begin
                     state_in = S_OUT;
                  end else if (sts.b_sole_orig) begin
                     cmd.byte_wr     = 1'b1;
                     cmd.byte_set_nb = 1'b1;
                     cmd.changed_set = 1'b1;
                     state_in        = S_PG_DIRTY;
                  end else begin
                     cmd.cand_op = CD_FIRST;
                     state_in    = S_M_NEXT;
                  end
               end
               default: state_in = S_OUT;
            endcase
         end
         S_L_RD: begin
            if (sts.cand_past) begin
               if (sts.full) begin
                  cmd.st_set  = 1'b1;
                  cmd.st_code = ST_FULL;
                  state_in    = S_OUT;
               end else begin
                  cmd.meta_wr = MW_NEW_LOAD;
                  cmd.tgt_op  = TG_NEW;
                  state_in    = S_L_LEAVE;
               end
            end else begin
               cmd.meta_rd = MR_CAND;
               cmd.tgt_op  = TG_CAND;
               state_in    = S_L_CHK;
            end
         end
         S_L_CHK: begin
            if (sts.load_hit) begin
               cmd.cap_tmeta = 1'b1;
               state_in      = S_L_INC;
            end else begin
               cmd.cand_op = CD_NEXT;
               state_in    = S_L_RD;
            end
         end
         S_L_INC: begin
            cmd.meta_wr = MW_INC;
            state_in    = S_L_LEAVE;
         end
         S_L_LEAVE: begin
            if (sts.leave_ok) begin
               cmd.meta_wr = MW_DEC;
            end
            state_in = S_L_PG;
         end
         S_L_PG: begin
            cmd.pg_wr = PW_TGT_CLEAN;
            state_in  = S_L_BYTE;
         end
         S_L_BYTE: state_in = S_L_CAPB;
         S_L_CAPB: begin
            cmd.cap_byte = 1'b1;
            state_in     = S_OUT;
         end
         S_M_NEXT: begin
            if (sts.cand_past) begin
               if (sts.b_ref_one) begin
                  cmd.byte_wr     = 1'b1;
                  cmd.byte_set_nb = 1'b1;
                  cmd.changed_set = 1'b1;
                  state_in        = S_PG_DIRTY;
               end else if (sts.full) begin
                  cmd.st_set  = 1'b1;
                  cmd.st_code = ST_FULL;
                  state_in    = S_OUT;
               end else begin
                  cmd.meta_wr   = MW_NEW_FORK;
                  cmd.tgt_op    = TG_NEW;
                  cmd.seq_start = 1'b1;
                  state_in      = S_M_COPY;
               end
            end else begin
               cmd.meta_rd = MR_CAND;
               cmd.tgt_op  = TG_CAND;
               state_in    = S_M_MCHK;
            end
         end
         S_M_MCHK: begin
            if (sts.cand_live) begin
               cmd.cap_tmeta = 1'b1;
               cmd.seq_start = 1'b1;
               state_in      = S_M_CMP;
            end else begin
               cmd.cand_op = CD_NEXT;
               state_in    = S_M_NEXT;
            end
         end
         S_M_CMP: begin
            cmd.cmp_step = 1'b1;
            if (sts.cmp_miss) begin
               cmd.cand_op = CD_NEXT;
               state_in    = S_M_NEXT;
            end else if (sts.cmp_hit) begin
               state_in = S_M_INC;
            end
         end
         S_M_COPY: begin
            cmd.copy_step = 1'b1;
            if (sts.copy_done) begin
               state_in = S_M_LEAVE;
            end
         end
         S_M_INC: begin
            cmd.meta_wr = MW_INC;
            state_in    = S_M_LEAVE;
         end
         S_M_LEAVE: begin
            if (sts.leave_ok) begin
               cmd.meta_wr = MW_DEC;
            end
            state_in = S_M_PG;
         end
         S_M_PG: begin
            cmd.pg_wr       = PW_TGT_DIRTY;
            cmd.byte_set_nb = 1'b1;
            cmd.changed_set = 1'b1;
            state_in        = S_OUT;
         end
         S_PG_DIRTY: begin
            cmd.pg_wr = PW_B_DIRTY;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
               rdy_in       = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rdy_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdy_ff   <= rdy_in;
      end
   end

   assign req_tready = rdy_ff;

endmodule

### design/dedup_copy_on_write_block_store.sv
// ----------------------------------------------------------------------------
// dedup_copy_on_write_block_store
// Shared, reference-counted byte blocks behind the pages of a code-point
// table, with copy-on-write byte edits and reuse of identical blocks.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields, lowest bit first
//  req_    | in  | action[3] code_point[21] source_address[23] new_byte[8] pad[1]
//  rsp_    | out | block_number[11] byte_value[8] changed page_dirty block_forked
//          |     | reference_count[15] status[2] pad[1]
//
//  A load searches the blocks in use for its address. A modify that must
//  search walks every block in use with the single byte store, and a fork
//  copies the whole block. After reset the page table is cleared before the
//  first transaction is taken. A stalled result is held in the output
//  register; one more request is then taken and held before its result.
// ----------------------------------------------------------------------------
module dedup_copy_on_write_block_store import dcow_pkg::*; #(
   parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEF,
   parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
   parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // action, code_point, source_address, new_byte
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // block_number, byte_value, changed, page_dirty, block_forked,
   // reference_count, status
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   cmd_type cmd;
   sts_type sts;

   dcow_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dcow_datapath #(
      .BLOCK_SHIFT (BLOCK_SHIFT),
      .PAGE_COUNT  (PAGE_COUNT),
      .MAX_BLOCKS  (MAX_BLOCKS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the deduplicated copy-on-write block store against a behavioural
// model of its page table and block store: directed loads, fills, edits and
// reads first, then a short random mix, with random gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import dcow_pkg::*;

   localparam int SHIFT     = BLOCK_SHIFT_DEF;
   localparam int PAGES     = PAGE_COUNT_DEF;
   localparam int BLOCKS    = MAX_BLOCKS_DEF;
   localparam int BLK_BYTES = 1 << SHIFT;
   localparam int IDLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;

   localparam logic [ACT_W-1:0] ACT_READ_PAGE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_READ_BYTE = 3'd4;
   localparam logic [ACT_W-1:0] ACT_SPARE     = 3'd7;

   typedef struct {
      logic [BLKNUM_W-1:0] blk;
      logic [BYTE_W-1:0]   byte_v;
      bit                  byte_known;
      bit                  changed;
      bit                  dirty;
      bit                  forked;
      logic [REF_W-1:0]    refs;
      status_type          status;
   } page_rsp_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // model of the store
   logic [BLKNUM_W-1:0] pg_blk   [PAGES];
   bit                  pg_dirty [PAGES];
   logic [BYTE_W-1:0]   blk_data [BLOCKS*BLK_BYTES];
   bit                  blk_wr   [BLOCKS*BLK_BYTES];
   logic [REF_W-1:0]    blk_refs [BLOCKS+1];
   bit                  blk_fork [BLOCKS+1];
   logic [ADDR_W-1:0]   blk_orig [BLOCKS+1];
   int                  live_blocks;

   page_rsp_type due_rsp[$];
   int        errors;
   int        burst_left;
   bit        hold_go;
   int        hold_left;
   int        phase_left;
   bit        steady;
   int        idle_cycles;
   logic [ADDR_W-1:0] addr_pool[8];
   logic [13:0]       page_pool[12];

   dedup_copy_on_write_block_store DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int byte_idx(int b, int off);
      return (b - 1) * BLK_BYTES + off;
   endfunction

   function automatic void ref_up(int b);
      if (blk_refs[b] != REF_MAX) blk_refs[b]++;
   endfunction

   function automatic void ref_leave(int b);
      if (b != 0 && blk_fork[b] && blk_refs[b] != 0) blk_refs[b]--;
   endfunction

   // Search live blocks for one equal to src with byte off set to val.
   function automatic int find_twin(int src, int off, logic [7:0] val);
      bit same;
      logic [7:0] want;
      for (int b = 1; b <= live_blocks; b++) begin
         if (blk_refs[b] == 0) continue;
         same = 1;
         for (int i = 0; i < BLK_BYTES; i++) begin
            want = (i == off) ? val : blk_data[byte_idx(src, i)];
            if (blk_data[byte_idx(b, i)] != want) begin
               same = 0;
               break;
            end
         end
         if (same) return b;
      end
      return 0;
   endfunction

   function automatic bit origin_live(logic [ADDR_W-1:0] addr);
      for (int f = 1; f <= live_blocks; f++)
         if (!blk_fork[f] && blk_refs[f] != 0 && blk_orig[f] == addr) return 1;
      return 0;
   endfunction

   function automatic page_rsp_type apply_request(logic [2:0] act, logic [20:0] cp,
                                                  logic [22:0] addr, logic [7:0] nb);
      page_rsp_type r;
      int page, off, b, f;
      status_type st;
      bit chg;
      page = cp >> SHIFT;
      off  = cp & (BLK_BYTES - 1);
      st   = ST_OK;
      chg  = 0;
      r    = '{default: 0, status: ST_OK};
      if (page >= PAGES) begin
         r.status = ST_RANGE;
         r.byte_known = 1;
         return r;
      end
      b = pg_blk[page];
      if (act == ACT_LOAD) begin
         if (addr == 0) begin
            ref_leave(b);
            pg_blk[page] = '0;
            pg_dirty[page] = 0;
         end else begin
            for (f = 1; f <= live_blocks; f++)
               if (!blk_fork[f] && blk_refs[f] != 0 && blk_orig[f] == addr) break;
            if (f <= live_blocks) ref_up(f);
            else if (live_blocks >= BLOCKS) st = ST_FULL;
            else begin
               live_blocks++;
               f = live_blocks;
               blk_refs[f] = REF_W'(1);
               blk_fork[f] = 0;
               blk_orig[f] = addr;
            end
            if (st == ST_OK) begin
               ref_leave(b);
               pg_blk[page] = BLKNUM_W'(f);
               pg_dirty[page] = 0;
            end
         end
      end else if (act == ACT_FILL) begin
         if (b == 0) st = ST_UNMAPPED;
         else begin
            blk_data[byte_idx(b, off)] = nb;
            blk_wr[byte_idx(b, off)] = 1;
         end
      end else if (act == ACT_MODIFY) begin
         if (b == 0) st = ST_UNMAPPED;
         else if (blk_data[byte_idx(b, off)] != nb) begin
            if (blk_refs[b] == 1 && !blk_fork[b]) begin
               blk_data[byte_idx(b, off)] = nb;
               chg = 1;
            end else begin
               f = find_twin(b, off, nb);
               if (f != 0) begin
                  ref_up(f);
                  ref_leave(b);
                  pg_blk[page] = BLKNUM_W'(f);
                  chg = 1;
               end else if (blk_refs[b] == 1) begin
                  blk_data[byte_idx(b, off)] = nb;
                  chg = 1;
               end else if (live_blocks >= BLOCKS) st = ST_FULL;
               else begin
                  live_blocks++;
                  f = live_blocks;
                  blk_refs[f] = REF_W'(1);
                  blk_fork[f] = 1;
                  blk_orig[f] = '0;
                  for (int i = 0; i < BLK_BYTES; i++) begin
                     blk_data[byte_idx(f, i)] = blk_data[byte_idx(b, i)];
                     blk_wr[byte_idx(f, i)] = blk_wr[byte_idx(b, i)];
                  end
                  blk_data[byte_idx(f, off)] = nb;
                  blk_wr[byte_idx(f, off)] = 1;
                  ref_leave(b);
                  pg_blk[page] = BLKNUM_W'(f);
                  chg = 1;
               end
            end
            if (chg) pg_dirty[page] = 1;
         end
      end
      b = pg_blk[page];
      r.blk     = BLKNUM_W'(b);
      r.changed = chg;
      r.dirty   = pg_dirty[page];
      r.status  = st;
      if (b != 0) begin
         r.byte_v     = blk_data[byte_idx(b, off)];
         r.byte_known = blk_wr[byte_idx(b, off)];
         r.forked     = blk_fork[b];
         r.refs       = blk_refs[b];
      end else r.byte_known = 1;
      return r;
   endfunction

   task automatic send_item(logic [2:0] act, logic [20:0] cp, logic [22:0] addr,
                            logic [7:0] nb);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata  = {1'b0, nb, addr, cp, act};
      do @(posedge clock); while (!req_tready);
      due_rsp.push_back(apply_request(act, cp, addr, nb));
   endtask

   // Load a page and, when that makes a fresh block, write every byte of it.
   task automatic load_page(int page, logic [22:0] addr);
      bit fresh;
      fresh = (addr != 0) && !origin_live(addr);
      send_item(ACT_LOAD, 21'(page << SHIFT) | 21'($urandom_range(0, BLK_BYTES-1)),
                addr, 8'($urandom));
      if (fresh)
         for (int i = 0; i < BLK_BYTES; i++)
            send_item(ACT_FILL, 21'((page << SHIFT) + i), 23'($urandom),
                      (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(0, 3)));
   endtask

   function automatic logic [20:0] cp_of(int page, int off);
      return 21'((page << SHIFT) + off);
   endfunction

   task automatic test_unmapped();
      send_item(ACT_READ_PAGE, cp_of(5, 3), 23'd0, 8'd0);
      send_item(ACT_FILL, cp_of(5, 3), 23'h7FFFFF, 8'hFF);
      send_item(ACT_MODIFY, cp_of(5, 4), 23'd0, 8'h55);
      send_item(ACT_READ_BYTE, cp_of(0, 0), 23'd0, 8'd0);
      send_item(ACT_SPARE, 21'h1FFFFF, 23'h7FFFFF, 8'hFF);
   endtask

   task automatic test_load_share();
      load_page(1, 23'h7FFFFF);
      send_item(ACT_MODIFY, cp_of(1, 1), 23'd0, 8'h00);   // sole original, in place
      load_page(2, 23'h7FFFFF);
      load_page(PAGES - 1, 23'h7FFFFF);
      send_item(ACT_READ_PAGE, cp_of(2, 1), 23'd0, 8'd0);
   endtask

   task automatic test_modify();
      send_item(ACT_MODIFY, cp_of(1, 0), 23'd0, 8'h00);   // same byte, no change
      send_item(ACT_MODIFY, cp_of(1, 2), 23'd0, 8'hA5);   // shared: fork
      send_item(ACT_MODIFY, cp_of(2, 2), 23'd0, 8'hA5);   // reuse the fork
      send_item(ACT_MODIFY, 21'h1FFFFF, 23'd0, 8'hFF);
      send_item(ACT_MODIFY, 21'h1FFFFF, 23'd0, 8'h00);
      send_item(ACT_LOAD, cp_of(1, 0), 23'd0, 8'd0);      // unmap, leave fork
      send_item(ACT_READ_BYTE, cp_of(2, 2), 23'd0, 8'd0);
      send_item(ACT_READ_PAGE, cp_of(1, 9), 23'd0, 8'd0);
      send_item(ACT_MODIFY, cp_of(2, 5), 23'd0, 8'hC3);   // sole fork owner, in place
      load_page(1, 23'h7FFFFF);
   endtask

   task automatic test_backpressure();
      hold_go = 1'b1;
      for (int i = 0; i < 6; i++)
         send_item(ACT_READ_BYTE, cp_of(page_pool[i], i), 23'($urandom), 8'($urandom));
   endtask

   task automatic test_random();
      int kind, page;
      logic [20:0] cp;
      for (int n = 0; n < 8; n++) begin
         kind = $urandom_range(0, 99);
         page = page_pool[$urandom_range(0, 11)];
         cp   = cp_of(page, $urandom_range(0, BLK_BYTES-1));
         // reload only the address already held, so no block needs filling
         if (kind < 12)
            load_page(page, ($urandom_range(0, 5) == 0) ? 23'd0 : addr_pool[0]);
         else if (kind < 25)
            send_item(ACT_FILL, cp, 23'($urandom), 8'($urandom_range(0, 3)));
         else if (kind < 70)
            send_item(ACT_MODIFY, cp, 23'($urandom),
                      ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
         else
            send_item(3'($urandom_range(ACT_READ_PAGE, ACT_SPARE)), cp, 23'($urandom),
                      8'($urandom));
      end
   endtask

   // result stalls: random pattern, steady stretches, and one long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else if (hold_go) begin
         hold_go = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_tready = 1'b0;
      end else begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(10, 60);
            steady = ($urandom_range(0, 2) == 0);
         end
         phase_left--;
         rsp_tready = steady ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      page_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_rsp.size() == 0) begin
            $error("result with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            e = due_rsp.pop_front();
            if (rsp_tdata[10:0] !== e.blk) begin
               $error("block_number expected %0d got %0d", e.blk, rsp_tdata[10:0]);
               errors++;
            end
            if (e.byte_known && rsp_tdata[18:11] !== e.byte_v) begin
               $error("byte_value expected %h got %h", e.byte_v, rsp_tdata[18:11]);
               errors++;
            end
            if (rsp_tdata[19] !== e.changed) begin
               $error("changed expected %0d got %0d", e.changed, rsp_tdata[19]);
               errors++;
            end
            if (rsp_tdata[20] !== e.dirty) begin
               $error("page_dirty expected %0d got %0d", e.dirty, rsp_tdata[20]);
               errors++;
            end
            if (rsp_tdata[21] !== e.forked) begin
               $error("block_forked expected %0d got %0d", e.forked, rsp_tdata[21]);
               errors++;
            end
            if (rsp_tdata[36:22] !== e.refs) begin
               $error("reference_count expected %0d got %0d", e.refs, rsp_tdata[36:22]);
               errors++;
            end
            if (rsp_tdata[38:37] !== e.status) begin
               $error("status expected %0d got %0d", e.status, rsp_tdata[38:37]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      errors      = 0;
      burst_left  = 0;
      hold_go     = 1'b0;
      hold_left   = 0;
      phase_left  = 0;
      steady      = 1'b0;
      idle_cycles = 0;
      live_blocks = 0;
      for (int p = 0; p < PAGES; p++) begin
         pg_blk[p] = '0;
         pg_dirty[p] = 0;
      end
      for (int b = 0; b <= BLOCKS; b++) begin
         blk_refs[b] = '0;
         blk_fork[b] = 0;
         blk_orig[b] = '0;
      end
      for (int i = 0; i < BLOCKS*BLK_BYTES; i++) begin
         blk_data[i] = '0;
         blk_wr[i] = 0;
      end
      addr_pool[0] = 23'h7FFFFF;
      addr_pool[1] = 23'd1;
      addr_pool[2] = 23'h400000;
      for (int i = 3; i < 8; i++) addr_pool[i] = 23'($urandom_range(2, 23'h7FFFFE));
      page_pool[0] = 14'd0;
      page_pool[1] = 14'(PAGES - 1);
      for (int i = 2; i < 12; i++) page_pool[i] = 14'($urandom);
      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_unmapped();
      test_load_share();
      test_modify();
      test_backpressure();
      test_random();

      @(negedge clock);
      req_tvalid = 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
